// ----- rtl/tod_pkg.sv -----
// ----------------------------------------------------------------------------
// tod_pkg
// Shared types and constants of the time-of-day alarm scheduler.
// ----------------------------------------------------------------------------
package tod_pkg;

	localparam int NUM_SLOTS     = 16;
	localparam int SLOT_W        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int RESULT_CAP    = 16;
	localparam int CAP_W         = $clog2(RESULT_CAP);
	localparam int SECS_PER_MIN  = 60;
	localparam int MINS_PER_HOUR = 60;
	localparam int HOURS_PER_DAY = 24;

	typedef enum logic [2:0] {
		MODE_TICK   = 3'd0,
		MODE_SET    = 3'd1,
		MODE_ADD    = 3'd2,
		MODE_DELETE = 3'd3,
		MODE_RETIME = 3'd4,
		MODE_INIT   = 3'd5
	} mode_t;

	localparam logic KIND_ADD  = 1'b0;
	localparam logic KIND_FIRE = 1'b1;

	typedef struct packed {
		logic [2:0] mode;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [3:0] slot;
		logic [7:0] task_code;
	} req_t;

	typedef struct packed {
		logic       kind;
		logic [3:0] slot_index;
		logic [7:0] code_out;
		logic       add_failed;
		logic       last;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic exec;
		logic match_load;
		logic scan_clr;
		logic scan_inc;
		logic add_write;
		logic fire_emit;
		logic add_emit_ok;
		logic add_emit_fail;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_tick;
		logic is_add;
		logic rollover;
		logic more_from;
		logic match_cur;
		logic fire_last;
		logic cur_free;
		logic scan_last;
	} stat_t;

endpackage

// ----- rtl/tod_ctrl.sv -----
// ----------------------------------------------------------------------------
// tod_ctrl
// Sequencer: accepts a request, runs the clock update and the slot scans.
// ----------------------------------------------------------------------------
module tod_ctrl import tod_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_MATCH,
		S_FIRE,
		S_ADD
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec     = 1'b1;
				cmd.scan_clr = 1'b1;
				if (stat.is_tick && stat.rollover) begin
					state_d = S_MATCH;
				end else if (stat.is_add) begin
					state_d = S_ADD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_MATCH: begin
				cmd.match_load = 1'b1;
				state_d        = S_FIRE;
			end
			S_FIRE: begin
				if (!stat.more_from) begin
					state_d = S_IDLE;
				end else if (stat.match_cur) begin
					cmd.fire_emit = 1'b1;
					if (stat.fire_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.scan_inc = 1'b1;
					end
				end else begin
					cmd.scan_inc = 1'b1;
				end
			end
			S_ADD: begin
				if (stat.cur_free) begin
					cmd.add_write   = 1'b1;
					cmd.add_emit_ok = 1'b1;
					state_d         = S_IDLE;
				end else if (stat.scan_last) begin
					cmd.add_emit_fail = 1'b1;
					state_d           = S_IDLE;
				end else begin
					cmd.scan_inc = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

// ----- rtl/tod_datapath.sv -----
// ----------------------------------------------------------------------------
// tod_datapath
// Clock registers, slot table, match vector, scan counter and result register.
// ----------------------------------------------------------------------------
module tod_datapath import tod_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  req_t       req,
	input  logic [5:0] cfg_data,
	input  logic       cfg_we,
	input  cmd_t       cmd,
	output stat_t      stat,
	output rsp_t       result,
	output logic       strobe
);

	req_t                req_q;
	logic [5:0]          spt_q;
	logic [4:0]          hours_q;
	logic [5:0]          minutes_q;
	logic [5:0]          seconds_q;
	logic [NUM_SLOTS-1:0] valid_q;
	logic [NUM_SLOTS-1:0] match_q;
	logic [4:0]          slot_hour_q   [NUM_SLOTS];
	logic [5:0]          slot_minute_q [NUM_SLOTS];
	logic [7:0]          slot_code_q   [NUM_SLOTS];
	logic [SLOT_W-1:0]   scan_idx_q;
	logic [CAP_W-1:0]    fire_cnt_q;
	rsp_t                result_q;
	logic                strobe_q;

	logic [5:0]          inc;
	logic [6:0]          sec_sum;
	logic                rollover;
	logic [5:0]          min_next;
	logic [4:0]          hour_next;
	logic                time_ok;
	logic                slot_ok;
	logic [SLOT_W-1:0]   req_idx;
	logic [NUM_SLOTS-1:0] match_vec;
	logic [NUM_SLOTS-1:0] at_or_above;
	logic [NUM_SLOTS-1:0] above;
	logic                fire_last;

	assign inc      = (spt_q > 6'(SECS_PER_MIN)) ? 6'(SECS_PER_MIN) : spt_q;
	assign sec_sum  = {1'b0, seconds_q} + {1'b0, inc};
	assign rollover = (sec_sum >= 7'(SECS_PER_MIN));
	assign time_ok  = (req_q.hour < 5'(HOURS_PER_DAY)) && (req_q.minute < 6'(MINS_PER_HOUR));
	assign slot_ok  = (32'(req_q.slot) < 32'(NUM_SLOTS));
	assign req_idx  = SLOT_W'(req_q.slot);

	always_comb begin
		if (minutes_q == 6'(MINS_PER_HOUR - 1)) begin
			min_next  = '0;
			hour_next = (hours_q == 5'(HOURS_PER_DAY - 1)) ? 5'd0 : hours_q + 5'd1;
		end else begin
			min_next  = minutes_q + 6'd1;
			hour_next = hours_q;
		end
	end

	// Each slot compares against the clock on its own; the results are scanned later.
	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			match_vec[i]   = valid_q[i] && (slot_hour_q[i] == hours_q) &&
			                 (slot_minute_q[i] == minutes_q);
			at_or_above[i] = (i >= int'(scan_idx_q));
			above[i]       = (i > int'(scan_idx_q));
		end
	end

	assign fire_last = ((match_q & above) == '0) || (fire_cnt_q == CAP_W'(RESULT_CAP - 1));

	assign stat.is_tick   = (req_q.mode == MODE_TICK);
	assign stat.is_add    = (req_q.mode == MODE_ADD);
	assign stat.rollover  = rollover;
	assign stat.more_from = ((match_q & at_or_above) != '0);
	assign stat.match_cur = match_q[scan_idx_q];
	assign stat.fire_last = fire_last;
	assign stat.cur_free  = !valid_q[scan_idx_q];
	assign stat.scan_last = (scan_idx_q == SLOT_W'(NUM_SLOTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spt_q     <= 6'd1;
			hours_q   <= '0;
			minutes_q <= '0;
			seconds_q <= '0;
			valid_q   <= '0;
			strobe_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				spt_q <= cfg_data;
			end
			strobe_q <= cmd.fire_emit || cmd.add_emit_ok || cmd.add_emit_fail;
			if (cmd.exec) begin
				case (req_q.mode)
					MODE_TICK: begin
						if (rollover) begin
							seconds_q <= 6'(sec_sum - 7'(SECS_PER_MIN));
							minutes_q <= min_next;
							hours_q   <= hour_next;
						end else begin
							seconds_q <= sec_sum[5:0];
						end
					end
					MODE_SET, MODE_INIT: begin
						if (time_ok) begin
							hours_q   <= req_q.hour;
							minutes_q <= req_q.minute;
							seconds_q <= '0;
							if (req_q.mode == MODE_INIT) begin
								valid_q <= '0;
							end
						end
					end
					MODE_DELETE: begin
						if (slot_ok) begin
							valid_q[req_idx] <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.add_write) begin
				valid_q[scan_idx_q] <= 1'b1;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.match_load) begin
			match_q <= match_vec;
		end
		if (cmd.scan_clr) begin
			scan_idx_q <= '0;
			fire_cnt_q <= '0;
		end else begin
			if (cmd.scan_inc) begin
				scan_idx_q <= scan_idx_q + SLOT_W'(1);
			end
			if (cmd.fire_emit) begin
				fire_cnt_q <= fire_cnt_q + CAP_W'(1);
			end
		end
		if (cmd.exec && (req_q.mode == MODE_RETIME) && slot_ok) begin
			slot_hour_q[req_idx]   <= req_q.hour;
			slot_minute_q[req_idx] <= req_q.minute;
		end
		if (cmd.add_write) begin
			slot_hour_q[scan_idx_q]   <= req_q.hour;
			slot_minute_q[scan_idx_q] <= req_q.minute;
			slot_code_q[scan_idx_q]   <= req_q.task_code;
		end
		if (cmd.fire_emit) begin
			result_q.kind       <= KIND_FIRE;
			result_q.slot_index <= 4'(scan_idx_q);
			result_q.code_out   <= slot_code_q[scan_idx_q];
			result_q.add_failed <= 1'b0;
			result_q.last       <= fire_last;
		end else if (cmd.add_emit_ok) begin
			result_q.kind       <= KIND_ADD;
			result_q.slot_index <= 4'(scan_idx_q);
			result_q.code_out   <= req_q.task_code;
			result_q.add_failed <= 1'b0;
			result_q.last       <= 1'b1;
		end else if (cmd.add_emit_fail) begin
			result_q.kind       <= KIND_ADD;
			result_q.slot_index <= '0;
			result_q.code_out   <= '0;
			result_q.add_failed <= 1'b1;
			result_q.last       <= 1'b1;
		end
	end

	assign result = result_q;
	assign strobe = strobe_q;

endmodule

// ----- rtl/time_of_day_alarm_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// time_of_day_alarm_scheduler_top
// 24-hour clock with an alarm slot table; fires matching slots on each minute.
// ----------------------------------------------------------------------------
//  channel   signals                     direction  transfer
//  request   start, busy, req            in         start && !busy
//  result    strobe, result              out        one cycle per strobe
//  config    cfg_valid, cfg_ready, cfg_data  in     cfg_valid && cfg_ready
//
// Set time, init, delete, retime and a tick without rollover pass through the exec state only.
// Add passes through exec, then scans for a free slot, visiting one slot a cycle.
// A tick with minute rollover passes through exec, match and fire; the fire state scans
// the latched matches, and each matching slot gives a registered result.
// Reset clears the clock, the valid marks and seconds_per_tick (to 1); no clearing pass.
// Results cannot be stalled; busy stays high until the last one is issued.
module time_of_day_alarm_scheduler_top import tod_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  req_t       req,
	output logic       strobe,
	output rsp_t       result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [5:0] cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	tod_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	tod_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg_data (cfg_data),
		.cfg_we   (cfg_valid && cfg_ready),
		.cmd      (cmd),
		.stat     (stat),
		.result   (result),
		.strobe   (strobe)
	);

endmodule

// ----- tb/sv/alarm_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// alarm_tb_pkg
// Result prediction and checking for the alarm scheduler testbench. The class
// keeps its own copy of the clock, the slot table and the tick size. It turns
// each accepted request into the results it should cause and compares those,
// in order, with what the block produces.
// ----------------------------------------------------------------------------
package alarm_tb_pkg;
	import tod_pkg::*;

	localparam int REPORT_LIMIT = 10;

	class alarm_scoreboard;
		logic [5:0]  tick_secs;
		logic [4:0]  clk_hour;
		logic [5:0]  clk_min;
		int unsigned clk_sec;
		bit          slot_used [NUM_SLOTS];
		logic [4:0]  slot_hr   [NUM_SLOTS];
		logic [5:0]  slot_mn   [NUM_SLOTS];
		logic [7:0]  slot_cd   [NUM_SLOTS];
		rsp_t        due_q [$];
		int unsigned n_requests;
		int unsigned n_results;
		int unsigned n_fires;
		int unsigned n_full;
		int unsigned largest_burst;
		int unsigned mismatches;

		function new();
			tick_secs     = 6'd1;
			clk_hour      = '0;
			clk_min       = '0;
			clk_sec       = 0;
			n_requests    = 0;
			n_results     = 0;
			n_fires       = 0;
			n_full        = 0;
			largest_burst = 0;
			mismatches    = 0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_used[i] = 1'b0;
				slot_hr[i]   = '0;
				slot_mn[i]   = '0;
				slot_cd[i]   = '0;
			end
		endfunction

		function void set_step(logic [5:0] v);
			tick_secs = v;
		endfunction

		function int unsigned pending();
			return due_q.size();
		endfunction

		function string show(rsp_t r);
			return $sformatf("kind=%0d slot=%0d code=%02h failed=%0d last=%0d",
				r.kind, r.slot_index, r.code_out, r.add_failed, r.last);
		endfunction

		function void record_request(req_t r);
			rsp_t        item;
			int unsigned step;
			int unsigned burst;
			bit          placed;
			n_requests++;
			item = '0;
			case (r.mode)
				MODE_TICK: begin
					// The increment saturates at one minute, so at most one rollover.
					step = (tick_secs > 6'd60) ? 60 : int'(tick_secs);
					clk_sec += step;
					if (clk_sec >= SECS_PER_MIN) begin
						clk_sec -= SECS_PER_MIN;
						if (clk_min == 6'(MINS_PER_HOUR - 1)) begin
							clk_min  = '0;
							clk_hour = (clk_hour == 5'(HOURS_PER_DAY - 1)) ? '0 : clk_hour + 5'd1;
						end else begin
							clk_min = clk_min + 6'd1;
						end
						burst = 0;
						for (int i = 0; i < NUM_SLOTS; i++) begin
							if (slot_used[i] && slot_hr[i] == clk_hour && slot_mn[i] == clk_min &&
								burst < RESULT_CAP) begin
								item.kind       = KIND_FIRE;
								item.slot_index = 4'(i);
								item.code_out   = slot_cd[i];
								item.add_failed = 1'b0;
								item.last       = 1'b0;
								due_q.push_back(item);
								burst++;
							end
						end
						if (burst > 0)
							due_q[due_q.size() - 1].last = 1'b1;
						if (burst > largest_burst)
							largest_burst = burst;
					end
				end
				MODE_SET, MODE_INIT: begin
					// An out-of-range time drops the whole request, slot clearing too.
					if (r.hour < HOURS_PER_DAY && r.minute < MINS_PER_HOUR) begin
						if (r.mode == MODE_INIT) begin
							for (int i = 0; i < NUM_SLOTS; i++)
								slot_used[i] = 1'b0;
						end
						clk_hour = r.hour;
						clk_min  = r.minute;
						clk_sec  = 0;
					end
				end
				MODE_ADD: begin
					placed    = 1'b0;
					item.kind = KIND_ADD;
					for (int i = 0; i < NUM_SLOTS; i++) begin
						if (!placed && !slot_used[i]) begin
							placed          = 1'b1;
							slot_used[i]    = 1'b1;
							slot_hr[i]      = r.hour;
							slot_mn[i]      = r.minute;
							slot_cd[i]      = r.task_code;
							item.slot_index = 4'(i);
							item.code_out   = r.task_code;
						end
					end
					if (!placed) begin
						item.add_failed = 1'b1;
						n_full++;
					end
					item.last = 1'b1;
					due_q.push_back(item);
				end
				MODE_DELETE: begin
					if (r.slot < NUM_SLOTS)
						slot_used[r.slot] = 1'b0;
				end
				MODE_RETIME: begin
					if (r.slot < NUM_SLOTS) begin
						slot_hr[r.slot] = r.hour;
						slot_mn[r.slot] = r.minute;
					end
				end
				default: begin
				end
			endcase
		endfunction

		function void compare_result(rsp_t got);
			rsp_t want;
			n_results++;
			if (due_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("ERROR: result with nothing expected: %s", show(got));
				return;
			end
			want = due_q.pop_front();
			if (want.kind == KIND_FIRE)
				n_fires++;
			if (got.kind !== want.kind || got.slot_index !== want.slot_index ||
				got.code_out !== want.code_out || got.add_failed !== want.add_failed ||
				got.last !== want.last) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("ERROR: result %0d expected %s", n_results, show(want));
					$display("ERROR: result %0d actual   %s", n_results, show(got));
				end
			end
		endfunction

		function void flag_leftovers();
			if (due_q.size() != 0) begin
				mismatches += due_q.size();
				$display("ERROR: %0d expected results never arrived", due_q.size());
			end
		endfunction
	endclass

endpackage

// ----- tb/sv/time_of_day_alarm_scheduler_top_tb.sv -----
// ----------------------------------------------------------------------------
// time_of_day_alarm_scheduler_top_tb
// Self-checking testbench of the time-of-day alarm scheduler. A directed
// opening covers ignored requests, a full slot table and a large alarm burst;
// random phases then run set/add/tick sequences aimed at the next minute,
// mixed with raw requests, under several tick sizes and random idle cycles.
// ----------------------------------------------------------------------------
module time_of_day_alarm_scheduler_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tod_pkg::*;
	import alarm_tb_pkg::*;

	localparam int CYCLE_LIMIT   = 100000;
	localparam int SETTLE_CYCLES = NUM_SLOTS + 4;
	localparam int IDLE_PCT      = 21;
	localparam int PHASE_ITEMS   = 18;
	localparam int NUM_PHASES    = 6;
	localparam int QUIET_PHASE   = 3;
	localparam logic [2:0] MODE_SPARE_A = 3'd6;
	localparam logic [2:0] MODE_SPARE_B = 3'd7;
	localparam logic [5:0] STEP_PLAN [NUM_PHASES] = '{6'd60, 6'd17, 6'd1, 6'd61, 6'd30, 6'd60};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       start;
	logic       busy;
	req_t       req;
	logic       strobe;
	rsp_t       result;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [5:0] cfg_data;

	alarm_scoreboard board;
	bit              idle_on;
	logic [5:0]      step_cfg;
	int unsigned     sent;
	int unsigned     cfg_writes;
	int unsigned     phase_end;
	int unsigned     cycle_count = 0;

	always #5 clk = ~clk;

	time_of_day_alarm_scheduler_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.strobe    (strobe),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Results are checked before the request of the same edge is recorded.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (strobe === 1'b1)
				board.compare_result(result);
			if (start && busy === 1'b0)
				board.record_request(req);
			if (cfg_valid && cfg_ready === 1'b1)
				board.set_step(cfg_data);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("ERROR: run stalled after %0d cycles", cycle_count);
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send(input logic [2:0] mode, input int hour, input int minute,
		input int slot, input int code);
		req_t r;
		r.mode      = mode;
		r.hour      = 5'(hour);
		r.minute    = 6'(minute);
		r.slot      = 4'(slot);
		r.task_code = 8'(code);
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy !== 1'b0);
		sent++;
	endtask

	task automatic write_step(input logic [5:0] v);
		start <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
		// A tick that rolls over without a match still passes through the match and fire states.
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (idle_on && $urandom_range(99) < IDLE_PCT)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		step_cfg = v;
		cfg_writes++;
	endtask

	// Set the clock, load alarms for the coming minute, then tick toward it.
	task automatic alarm_burst();
		int hh;
		int mm;
		int due_hh;
		int due_mm;
		int n_add;
		int n_tick;
		int step;
		bit fill;
		fill = ($urandom_range(4) == 0);
		hh = ($urandom_range(3) == 0) ? 23 : int'($urandom_range(23));
		mm = ($urandom_range(3) == 0) ? 59 : int'($urandom_range(59));
		send((fill || $urandom_range(2) == 0) ? MODE_INIT : MODE_SET, hh, mm,
			$urandom_range(15), $urandom_range(255));
		due_mm = (mm + 1) % MINS_PER_HOUR;
		due_hh = (mm == MINS_PER_HOUR - 1) ? (hh + 1) % HOURS_PER_DAY : hh;
		n_add = fill ? NUM_SLOTS + 1 : int'($urandom_range(1, 6));
		for (int k = 0; k < n_add; k++) begin
			if (fill || $urandom_range(3) != 0)
				send(MODE_ADD, due_hh, due_mm, $urandom_range(15), $urandom_range(255));
			else
				send(MODE_ADD, $urandom_range(31), $urandom_range(63), $urandom_range(15),
					$urandom_range(255));
			if (!fill && $urandom_range(4) == 0)
				send(MODE_DELETE, $urandom_range(31), $urandom_range(63), $urandom_range(15),
					$urandom_range(255));
			if (!fill && $urandom_range(4) == 0)
				send(MODE_RETIME, due_hh, due_mm, $urandom_range(15), $urandom_range(255));
		end
		step = (step_cfg > 6'd60) ? 60 : int'(step_cfg);
		n_tick = (step == 0) ? 2 : (SECS_PER_MIN + step - 1) / step;
		if (n_tick > 4)
			n_tick = $urandom_range(2, 4);
		repeat (n_tick)
			send(MODE_TICK, $urandom_range(31), $urandom_range(63), $urandom_range(15),
				$urandom_range(255));
	endtask

	initial begin
		board = new();
		arst_n    <= 1'b0;
		start     <= 1'b0;
		req       <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		idle_on    = 1'b1;
		step_cfg   = 6'd1;
		sent       = 0;
		cfg_writes = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Requests that must produce no result, at the reset tick size.
		send(MODE_TICK, 0, 0, 0, 0);
		send(MODE_SET, 24, 0, 0, 0);
		send(MODE_SET, 12, 60, 0, 0);
		send(MODE_INIT, 31, 63, 15, 255);
		send(MODE_SPARE_A, 31, 63, 15, 255);
		send(MODE_SPARE_B, 0, 0, 0, 0);

		// Fill the table, overflow it once, then fire almost every slot at midnight.
		write_step(6'd63);
		send(MODE_INIT, 23, 59, 0, 0);
		send(MODE_ADD, 31, 63, 0, 8'hA5);
		for (int k = 1; k < NUM_SLOTS; k++)
			send(MODE_ADD, 0, 0, 0, k * 17);
		send(MODE_ADD, 0, 0, 0, 8'h3C);
		send(MODE_DELETE, 0, 0, 1, 0);
		send(MODE_RETIME, 0, 0, 1, 0);
		send(MODE_RETIME, 0, 0, 0, 0);
		send(MODE_TICK, 0, 0, 0, 0);

		write_step(6'd0);
		send(MODE_TICK, 0, 0, 0, 0);
		send(MODE_TICK, 31, 63, 15, 255);

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_step(STEP_PLAN[p]);
			idle_on   = (p != QUIET_PHASE);
			phase_end = sent + PHASE_ITEMS;
			while (sent < phase_end) begin
				if ($urandom_range(99) < 60)
					alarm_burst();
				else
					send(3'($urandom_range(7)), $urandom_range(31), $urandom_range(63),
						$urandom_range(15), $urandom_range(255));
			end
		end

		start <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		board.flag_leftovers();

		$display("Covered %0d requests and %0d results: %0d alarm fires, largest burst %0d.",
			board.n_requests, board.n_results, board.n_fires, board.largest_burst);
		$display("Add on a full table %0d times; %0d tick size writes; %0d mismatches.",
			board.n_full, cfg_writes, board.mismatches);
		if (board.mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/tod_pkg.sv
rtl/tod_ctrl.sv
rtl/tod_datapath.sv
rtl/time_of_day_alarm_scheduler_top.sv
tb/sv/alarm_tb_pkg.sv
tb/sv/time_of_day_alarm_scheduler_top_tb.sv
